// ===== src/mpae_pkg.sv =====
// Shared codes and types of the memory patch apply engine.
package mpae_pkg;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_PATCH = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_REPLACE = 2'd0,
      KIND_ADD     = 2'd1,
      KIND_COPY    = 2'd2,
      KIND_SKIP    = 2'd3
   } kind_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUS_READ,
      ST_BYTE,
      ST_MODIFY,
      ST_DONE
   } state_type;

endpackage

// ===== src/mpae_req_if.sv =====
// Request channel of the memory patch apply engine.
interface mpae_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] address;
   logic [7:0]  write_byte;
   logic [1:0]  patch_kind;
   logic [3:0]  byte_count;
   logic        big_endian;
   logic [63:0] patch_value;
   logic [7:0]  repeat_count;
   logic [15:0] address_step;
   logic [63:0] value_step;
   logic [15:0] copy_source;
   logic [15:0] copy_step;

   modport source (
      output valid, req_type, address, write_byte, patch_kind, byte_count, big_endian,
             patch_value, repeat_count, address_step, value_step, copy_source, copy_step,
      input  ready
   );
   modport sink (
      input  valid, req_type, address, write_byte, patch_kind, byte_count, big_endian,
             patch_value, repeat_count, address_step, value_step, copy_source, copy_step,
      output ready
   );
endinterface

// ===== src/mpae_rsp_if.sv =====
// Response channel of the memory patch apply engine.
interface mpae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_byte;
   logic       applied;

   modport source (output valid, read_byte, applied, input ready);
   modport sink (input valid, read_byte, applied, output ready);
endinterface

// ===== src/mpae_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mpae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/memory_patch_apply_engine_unit.sv =====
// Top level of the memory patch apply engine: request sequencer around one byte RAM.
//
//   channel   dir  handshake            payload
//   req_port  in   valid/ready          req_type, address, write_byte, patch fields
//   rsp_port  out  valid/ready          read_byte, applied
//   csr_*     in   csr_wr_en, no wait   csr_wr_data = cheats_active
//
// Write and unused requests go from idle to done, a read through a bus-read state first,
// a skipped or empty patch straight to done. A replace patch writes one byte per step;
// in add and copy mode each byte reads the RAM, then writes it back in the next cycle.
// One item is in work at a time; the next is taken while a response waits in the
// output register. A stalled response holds the sequencer in its last state.
// Reset is synchronous and clears the sequencer, the output valid and sets cheats_active.
module memory_patch_apply_engine_unit
   import mpae_pkg::*;
#(
   parameter int ADDR_BITS  = 16,
   parameter int MAX_REPEAT = 255,
   parameter int MAX_BYTES  = 8
) (
   input  logic           clock,
   input  logic           reset,
   mpae_req_if.sink       req_port,
   mpae_rsp_if.source     rsp_port,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data
);
   localparam int MemDepth = 2 ** ADDR_BITS;
   localparam int RepW     = $clog2(MAX_REPEAT + 1);
   localparam int LenW     = $clog2(MAX_BYTES + 1);

   function automatic logic [ADDR_BITS-1:0] fit_addr(input logic [15:0] a);
      logic [ADDR_BITS+15:0] w;
      w = {{ADDR_BITS{1'b0}}, a};
      return w[ADDR_BITS-1:0];
   endfunction

   state_type              state_ff, state_in;
   logic                   cheats_active_ff;
   logic [LenW-1:0]        x_ff, x_in, len_ff, len_in;
   logic                   big_ff, big_in;
   kind_code_type          kind_ff, kind_in;
   logic [RepW-1:0]        rem_ff, rem_in;
   logic [ADDR_BITS-1:0]   dst_ff, dst_in, src_ff, src_in;
   logic [ADDR_BITS-1:0]   astep_ff, astep_in, sstep_ff, sstep_in;
   logic [63:0]            val_ff, val_in, vstep_ff, vstep_in, work_ff, work_in;
   logic                   carry_ff, carry_in;
   logic [7:0]             res_byte_ff, res_byte_in;
   logic                   res_applied_ff, res_applied_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic                   rsp_applied_ff, rsp_applied_in;

   logic                   ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0]   ram_wr_addr, ram_rd_addr;
   logic [7:0]             ram_wr_data, ram_rd_data;

   logic [LenW-1:0]        off;
   logic [ADDR_BITS-1:0]   off_ext, tgt_addr, src_addr;
   logic [8:0]             sum;
   logic [63:0]            val_next;
   logic                   step;
   logic [LenW-1:0]        len_req;
   logic [RepW-1:0]        reps_req;

   mpae_ram #(.WIDTH(8), .DEPTH(MemDepth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign off      = big_ff ? (len_ff - LenW'(1) - x_ff) : x_ff;
   assign off_ext  = {{(ADDR_BITS-LenW){1'b0}}, off};
   assign tgt_addr = dst_ff + off_ext;
   assign src_addr = src_ff + off_ext;
   assign sum      = {1'b0, ram_rd_data} + {1'b0, work_ff[7:0]} + {8'b0, carry_ff};
   assign val_next = val_ff + vstep_ff;

   assign len_req  = (int'(req_port.byte_count) > MAX_BYTES) ? LenW'(MAX_BYTES)
                                                             : LenW'(req_port.byte_count);
   assign reps_req = (int'(req_port.repeat_count) > MAX_REPEAT) ? RepW'(MAX_REPEAT)
                                                                : RepW'(req_port.repeat_count);

   assign req_port.ready     = (state_ff == ST_IDLE);
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.read_byte = rsp_byte_ff;
   assign rsp_port.applied   = rsp_applied_ff;

   always_comb begin
      state_in       = state_ff;
      x_in           = x_ff;
      len_in         = len_ff;
      big_in         = big_ff;
      kind_in        = kind_ff;
      rem_in         = rem_ff;
      dst_in         = dst_ff;
      src_in         = src_ff;
      astep_in       = astep_ff;
      sstep_in       = sstep_ff;
      val_in         = val_ff;
      vstep_in       = vstep_ff;
      work_in        = work_ff;
      carry_in       = carry_ff;
      res_byte_in    = res_byte_ff;
      res_applied_in = res_applied_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_port.ready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_applied_in = rsp_applied_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = tgt_addr;
      ram_wr_data    = work_ff[7:0];
      ram_rd_en      = 1'b0;
      ram_rd_addr    = tgt_addr;
      step           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               // latch patch fields on every accept; only patches use them
               dst_in         = fit_addr(req_port.address);
               src_in         = fit_addr(req_port.copy_source);
               astep_in       = fit_addr(req_port.address_step);
               sstep_in       = fit_addr(req_port.copy_step);
               val_in         = req_port.patch_value;
               work_in        = req_port.patch_value;
               vstep_in       = req_port.value_step;
               kind_in        = kind_code_type'(req_port.patch_kind);
               big_in         = req_port.big_endian;
               len_in         = len_req;
               rem_in         = reps_req;
               x_in           = '0;
               carry_in       = 1'b0;
               res_byte_in    = 8'd0;
               res_applied_in = 1'b0;
               state_in       = ST_DONE;
               case (req_code_type'(req_port.req_type))
                  REQ_WRITE: begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = fit_addr(req_port.address);
                     ram_wr_data = req_port.write_byte;
                  end
                  REQ_READ: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = fit_addr(req_port.address);
                     state_in    = ST_BUS_READ;
                  end
                  REQ_PATCH: begin
                     if (cheats_active_ff &&
                         kind_code_type'(req_port.patch_kind) != KIND_SKIP) begin
                        res_applied_in = 1'b1;
                        if (len_req != '0 && reps_req != '0) begin
                           state_in = ST_BYTE;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BUS_READ: begin
            res_byte_in = ram_rd_data;
            state_in    = ST_DONE;
         end
         ST_BYTE: begin
            if (kind_ff == KIND_REPLACE) begin
               ram_wr_en = 1'b1;
               step      = 1'b1;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = (kind_ff == KIND_ADD) ? tgt_addr : src_addr;
               state_in    = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            // write lands before the next byte's read, so copy overlap sees new data
            ram_wr_en   = 1'b1;
            ram_wr_data = (kind_ff == KIND_ADD) ? sum[7:0] : ram_rd_data;
            carry_in    = sum[8];
            step        = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = res_byte_ff;
               rsp_applied_in = res_applied_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (step) begin
         if (x_ff == len_ff - LenW'(1)) begin
            // end of repetition: advance target, value and source
            x_in     = '0;
            carry_in = 1'b0;
            dst_in   = dst_ff + astep_ff;
            src_in   = src_ff + sstep_ff;
            val_in   = val_next;
            work_in  = val_next;
            rem_in   = rem_ff - RepW'(1);
            state_in = (rem_ff == RepW'(1)) ? ST_DONE : ST_BYTE;
         end else begin
            x_in     = x_ff + LenW'(1);
            work_in  = {8'd0, work_ff[63:8]};
            state_in = ST_BYTE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         cheats_active_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cheats_active_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      len_ff         <= len_in;
      big_ff         <= big_in;
      kind_ff        <= kind_in;
      rem_ff         <= rem_in;
      dst_ff         <= dst_in;
      src_ff         <= src_in;
      astep_ff       <= astep_in;
      sstep_ff       <= sstep_in;
      val_ff         <= val_in;
      vstep_ff       <= vstep_in;
      work_ff        <= work_in;
      carry_ff       <= carry_in;
      res_byte_ff    <= res_byte_in;
      res_applied_ff <= res_applied_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_applied_ff <= rsp_applied_in;
   end

   a_modify_after_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MODIFY |-> $past(state_ff) == ST_BYTE)
      else $error("modify step without a preceding read");

   a_byte_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BYTE || state_ff == ST_MODIFY) |-> (x_ff < len_ff && rem_ff != '0))
      else $error("byte index or repetition count out of range");

   a_no_write_on_bus_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUS_READ |-> !ram_wr_en && $past(ram_rd_en))
      else $error("bus read without a RAM read");

   a_result_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_applied_ff |-> rsp_byte_ff == 8'd0)
      else $error("patch response carries read data");

endmodule

// ===== test/tb_memory_patch_apply_engine_unit.sv =====
// Testbench for the memory patch apply engine: directed table plus random requests vs. a mirror.
module tb_memory_patch_apply_engine_unit;
   import mpae_pkg::*;

   typedef struct {
      req_code_type  req_type;
      logic [15:0]   address;
      logic [7:0]    write_byte;
      kind_code_type patch_kind;
      logic [3:0]    byte_count;
      logic          big_endian;
      logic [63:0]   patch_value;
      logic [7:0]    repeat_count;
      logic [15:0]   address_step;
      logic [63:0]   value_step;
      logic [15:0]   copy_source;
      logic [15:0]   copy_step;
   } request_t;

   typedef struct {
      logic [7:0] read_byte;
      logic       applied;
   } response_t;

   typedef struct {
      int        csr_set;
      request_t  req;
      bit        typed;
      response_t rsp;
   } script_row_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   mpae_req_if req_if ();
   mpae_rsp_if rsp_if ();

   memory_patch_apply_engine_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_if),
      .rsp_port   (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // mirror of the byte memory and of which bytes hold defined data
   logic [7:0]  mem_image [0:65535];
   bit          mem_valid [0:65535];
   logic [15:0] bus_written [$];
   bit          cheats_on;

   response_t   rsp_due [$];
   script_row_t script [$];
   bit          calm;
   int          n_errors;
   int          n_items;
   int          n_applied;
   int          n_reads;

   always #4 clock = ~clock;

   function automatic int pause_len();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   function automatic request_t rq(req_code_type t, logic [15:0] a, logic [7:0] d);
      request_t r;
      r.req_type     = t;
      r.address      = a;
      r.write_byte   = d;
      r.patch_kind   = KIND_REPLACE;
      r.byte_count   = 4'd0;
      r.big_endian   = 1'b0;
      r.patch_value  = 64'd0;
      r.repeat_count = 8'd0;
      r.address_step = 16'd0;
      r.value_step   = 64'd0;
      r.copy_source  = 16'd0;
      r.copy_step    = 16'd0;
      return r;
   endfunction

   function automatic request_t rq_patch(kind_code_type k, logic [15:0] a, logic [3:0] len,
                                         logic big, logic [63:0] value, logic [7:0] reps,
                                         logic [15:0] astep, logic [63:0] vstep,
                                         logic [15:0] src, logic [15:0] sstep);
      request_t r;
      r = rq(REQ_PATCH, a, 8'h00);
      r.patch_kind   = k;
      r.byte_count   = len;
      r.big_endian   = big;
      r.patch_value  = value;
      r.repeat_count = reps;
      r.address_step = astep;
      r.value_step   = vstep;
      r.copy_source  = src;
      r.copy_step    = sstep;
      return r;
   endfunction

   // Walk every byte of a patch. With commit clear, only report whether every byte the
   // patch reads holds defined data; with commit set, update the mirror.
   function automatic bit walk_patch(request_t r, bit commit);
      int          n_bytes;
      int          off;
      logic [15:0] dst;
      logic [15:0] src;
      logic [15:0] ta;
      logic [15:0] sa;
      logic [63:0] val;
      logic [8:0]  sum;
      logic        carry;
      bit          fresh [int];
      n_bytes = (r.byte_count > 4'd8) ? 8 : int'(r.byte_count);
      dst = r.address;
      src = r.copy_source;
      val = r.patch_value;
      for (int rep = 0; rep < int'(r.repeat_count); rep++) begin
         carry = 1'b0;
         for (int x = 0; x < n_bytes; x++) begin
            off = r.big_endian ? n_bytes - 1 - x : x;
            ta  = dst + 16'(off);
            sa  = src + 16'(off);
            if (!commit) begin
               if (r.patch_kind == KIND_ADD && !mem_valid[ta] && !fresh.exists(ta))
                  return 1'b0;
               if (r.patch_kind == KIND_COPY && !mem_valid[sa] && !fresh.exists(sa))
                  return 1'b0;
               fresh[ta] = 1'b1;
            end else begin
               case (r.patch_kind)
                  KIND_ADD: begin
                     sum   = {1'b0, mem_image[ta]} + {1'b0, val[8*x +: 8]} + {8'd0, carry};
                     carry = sum[8];
                     mem_image[ta] = sum[7:0];
                  end
                  KIND_COPY: mem_image[ta] = mem_image[sa];
                  default:   mem_image[ta] = val[8*x +: 8];
               endcase
               mem_valid[ta] = 1'b1;
            end
         end
         dst += r.address_step;
         val += r.value_step;
         src += r.copy_step;
      end
      return 1'b1;
   endfunction

   function automatic response_t predict_response(request_t r);
      response_t rsp;
      rsp.read_byte = 8'h00;
      rsp.applied   = 1'b0;
      n_items++;
      case (r.req_type)
         REQ_WRITE: begin
            mem_image[r.address] = r.write_byte;
            mem_valid[r.address] = 1'b1;
            bus_written.push_back(r.address);
            if (bus_written.size() > 64)
               void'(bus_written.pop_front());
         end
         REQ_READ: begin
            rsp.read_byte = mem_image[r.address];
            n_reads++;
         end
         REQ_PATCH: begin
            if (cheats_on && r.patch_kind != KIND_SKIP) begin
               void'(walk_patch(r, 1'b1));
               rsp.applied = 1'b1;
               n_applied++;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // the fill patch of the directed part leaves FF00..06F7 defined
   function automatic logic [15:0] window_byte();
      return 16'hFF00 + 16'($urandom_range(0, 2039));
   endfunction

   function automatic logic [15:0] stride();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(0, 16));
         1:       return 16'h0000 - 16'($urandom_range(1, 16));
         2:       return 16'($urandom);
         default: return 16'($urandom_range(0, 4));
      endcase
   endfunction

   function automatic request_t random_request();
      request_t r;
      int       pick;
      int       sel;
      // randomize unused fields too
      r.req_type     = REQ_NONE;
      r.address      = 16'($urandom);
      r.write_byte   = 8'($urandom);
      r.patch_kind   = kind_code_type'(2'($urandom));
      r.byte_count   = 4'($urandom);
      r.big_endian   = 1'($urandom);
      r.patch_value  = {$urandom, $urandom};
      r.repeat_count = 8'($urandom);
      r.address_step = 16'($urandom);
      r.value_step   = {$urandom, $urandom};
      r.copy_source  = 16'($urandom);
      r.copy_step    = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
         r.req_type = REQ_WRITE;
         if ($urandom_range(0, 1) == 0)
            r.address = window_byte();
      end else if (pick < 54) begin
         r.req_type = REQ_READ;
         sel = $urandom_range(0, 2);
         if (sel == 0 && bus_written.size() > 0)
            r.address = bus_written[$urandom_range(0, bus_written.size() - 1)];
         else if (sel == 2)
            r.address = window_byte();
         // never read a byte that holds no defined data
         if (!mem_valid[r.address])
            r.address = window_byte();
      end else if (pick < 96) begin
         r.req_type = REQ_PATCH;
         sel = $urandom_range(0, 99);
         r.patch_kind = sel < 30 ? KIND_REPLACE : sel < 60 ? KIND_ADD :
                        sel < 90 ? KIND_COPY : KIND_SKIP;
         sel = $urandom_range(0, 99);
         r.byte_count = sel < 90 ? 4'($urandom_range(1, 8)) :
                        sel < 95 ? 4'd0 : 4'($urandom_range(9, 15));
         sel = $urandom_range(0, 199);
         r.repeat_count = sel < 170 ? 8'($urandom_range(0, 6)) :
                          sel < 197 ? 8'($urandom_range(7, 40)) : 8'($urandom_range(200, 255));
         if (r.patch_kind != KIND_REPLACE || $urandom_range(0, 1) == 0)
            r.address = window_byte();
         r.address_step = stride();
         r.copy_step    = stride();
         if ($urandom_range(0, 1) == 0)
            r.value_step = 64'($urandom_range(0, 300));
         if (r.patch_kind == KIND_COPY)
            r.copy_source = window_byte();
         // fall back to replace where the patch would read undefined bytes
         if (cheats_on && r.patch_kind != KIND_SKIP && !walk_patch(r, 1'b0))
            r.patch_kind = KIND_REPLACE;
      end
      return r;
   endfunction

   task automatic add_row(int csr, request_t r, bit typed, logic [7:0] rb, logic ap);
      script_row_t row;
      row.csr_set       = csr;
      row.req           = r;
      row.typed         = typed;
      row.rsp.read_byte = rb;
      row.rsp.applied   = ap;
      script.push_back(row);
   endtask

   task automatic set_cheats(bit on);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (rsp_due.size() != 0)
         @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= on;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cheats_on = on;
   endtask

   task automatic send_request(request_t r, bit typed, response_t typed_rsp);
      int        gap;
      response_t rsp;
      gap = pause_len();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.req_type     <= r.req_type;
      req_if.address      <= r.address;
      req_if.write_byte   <= r.write_byte;
      req_if.patch_kind   <= r.patch_kind;
      req_if.byte_count   <= r.byte_count;
      req_if.big_endian   <= r.big_endian;
      req_if.patch_value  <= r.patch_value;
      req_if.repeat_count <= r.repeat_count;
      req_if.address_step <= r.address_step;
      req_if.value_step   <= r.value_step;
      req_if.copy_source  <= r.copy_source;
      req_if.copy_step    <= r.copy_step;
      req_if.valid        <= 1'b1;
      do @(posedge clock); while (!req_if.ready);
      rsp = predict_response(r);
      rsp_due.push_back(typed ? typed_rsp : rsp);
   endtask

   always @(posedge clock) begin
      response_t due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (rsp_due.size() == 0) begin
            $error("unexpected item: read_byte %0h applied %0b",
                   rsp_if.read_byte, rsp_if.applied);
            n_errors++;
         end else begin
            due = rsp_due.pop_front();
            if (rsp_if.read_byte !== due.read_byte) begin
               $error("read_byte: expected %0h, actual %0h", due.read_byte, rsp_if.read_byte);
               n_errors++;
            end
            if (rsp_if.applied !== due.applied) begin
               $error("applied: expected %0b, actual %0b", due.applied, rsp_if.applied);
               n_errors++;
            end
         end
      end
   end

   // result side: hold ready low for a drawn number of cycles before each item
   initial begin
      int hold;
      rsp_if.ready = 1'b0;
      forever begin
         hold = pause_len();
         @(negedge clock);
         if (hold > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && !reset));
      end
   end

   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      response_t no_rsp;
      int        guard;
      clock               = 1'b0;
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = 1'b0;
      req_if.valid        = 1'b0;
      req_if.req_type     = REQ_WRITE;
      req_if.address      = 16'd0;
      req_if.write_byte   = 8'd0;
      req_if.patch_kind   = KIND_REPLACE;
      req_if.byte_count   = 4'd0;
      req_if.big_endian   = 1'b0;
      req_if.patch_value  = 64'd0;
      req_if.repeat_count = 8'd0;
      req_if.address_step = 16'd0;
      req_if.value_step   = 64'd0;
      req_if.copy_source  = 16'd0;
      req_if.copy_step    = 16'd0;
      no_rsp.read_byte    = 8'h00;
      no_rsp.applied      = 1'b0;
      cheats_on           = 1'b1;
      calm                = 1'b0;
      n_errors            = 0;
      n_items             = 0;
      n_applied           = 0;
      n_reads             = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_cheats(1'b1);

      // fill FF00..06F7 so later reads, adds and copies see defined bytes
      add_row(-1, rq_patch(KIND_REPLACE, 16'hFF00, 4'd8, 1'b0, 64'h0706050403020100, 8'd255,
                           16'd8, 64'h0808080808080808, 16'h0000, 16'h0000), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'hFF00, 8'h00), 1, 8'h00, 1'b0);
      add_row(-1, rq(REQ_READ, 16'hFF07, 8'h00), 1, 8'h07, 1'b0);
      add_row(-1, rq(REQ_WRITE, 16'hFFFF, 8'hFF), 1, 8'h00, 1'b0);
      add_row(-1, rq(REQ_WRITE, 16'h0000, 8'h12), 1, 8'h00, 1'b0);
      add_row(-1, rq(REQ_WRITE, 16'h0010, 8'hFF), 1, 8'h00, 1'b0);
      // carry across the address wrap
      add_row(-1, rq_patch(KIND_ADD, 16'hFFFF, 4'd2, 1'b0, 64'd1, 8'd1,
                           16'd0, 64'd0, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'hFFFF, 8'h00), 1, 8'h00, 1'b0);
      add_row(-1, rq(REQ_READ, 16'h0000, 8'h00), 1, 8'h13, 1'b0);
      // drop the final carry
      add_row(-1, rq_patch(KIND_ADD, 16'h0010, 4'd1, 1'b0, 64'd1, 8'd1,
                           16'd0, 64'd0, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'h0010, 8'h00), 1, 8'h00, 1'b0);
      add_row(-1, rq_patch(KIND_REPLACE, 16'h0020, 4'd4, 1'b1, 64'h11223344, 8'd1,
                           16'd0, 64'd0, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'h0023, 8'h00), 1, 8'h44, 1'b0);
      // overlapping copy reads bytes it has just written
      add_row(-1, rq_patch(KIND_COPY, 16'h0031, 4'd8, 1'b0, 64'd0, 8'd2,
                           16'd8, 64'd0, 16'h0030, 16'd8), 0, 8'h00, 1'b0);
      add_row(-1, rq(REQ_READ, 16'h0039, 8'h00), 0, 8'h00, 1'b0);
      add_row(-1, rq_patch(KIND_SKIP, 16'h0040, 4'd8, 1'b0, 64'hFF, 8'd4,
                           16'd1, 64'd1, 16'd0, 16'd0), 1, 8'h00, 1'b0);
      add_row(-1, rq_patch(KIND_REPLACE, 16'h0050, 4'd8, 1'b0, 64'hFF, 8'd0,
                           16'd1, 64'd1, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      add_row(-1, rq_patch(KIND_REPLACE, 16'h0050, 4'd0, 1'b0, 64'hFF, 8'd3,
                           16'd1, 64'd1, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      // oversized byte count, all-ones fields, backward step
      add_row(-1, rq_patch(KIND_ADD, 16'h0060, 4'd15, 1'b1, {64{1'b1}}, 8'd2,
                           16'hFFFF, {64{1'b1}}, 16'hFFFF, 16'hFFFF), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'h0067, 8'h00), 0, 8'h00, 1'b0);
      add_row(-1, rq(REQ_NONE, 16'hFFFF, 8'hFF), 1, 8'h00, 1'b0);
      add_row(0, rq_patch(KIND_REPLACE, 16'h0070, 4'd8, 1'b0, {64{1'b1}}, 8'd1,
                          16'd0, 64'd0, 16'd0, 16'd0), 1, 8'h00, 1'b0);
      add_row(-1, rq(REQ_READ, 16'h0070, 8'h00), 0, 8'h00, 1'b0);
      add_row(1, rq_patch(KIND_REPLACE, 16'hFFFC, 4'd8, 1'b1, 64'h0123456789ABCDEF, 8'd1,
                          16'd0, 64'd0, 16'd0, 16'd0), 1, 8'h00, 1'b1);
      add_row(-1, rq(REQ_READ, 16'h0003, 8'h00), 0, 8'h00, 1'b0);

      foreach (script[i]) begin
         if (script[i].csr_set >= 0)
            set_cheats(script[i].csr_set[0]);
         send_request(script[i].req, script[i].typed, script[i].rsp);
      end

      for (int phase = 0; phase < 6; phase++) begin
         set_cheats(phase != 2);
         for (int n = 0; n < 305; n++) begin
            // switch between idle-free stretches and random gaps
            if (n % 100 == 0)
               calm = ($urandom_range(0, 3) == 0);
            send_request(random_request(), 1'b0, no_rsp);
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      guard = 0;
      while (rsp_due.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (32) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $error("%0d items never arrived", rsp_due.size());
         n_errors++;
      end

      $display("%0d requests: %0d patches carried out, %0d bytes read back",
               n_items, n_applied, n_reads);
      $display("patch kinds, byte orders and address wrap run with cheats on and off");
      if (n_errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/mpae_pkg.sv
src/mpae_req_if.sv
src/mpae_rsp_if.sv
src/mpae_ram.sv
src/memory_patch_apply_engine_unit.sv
test/tb_memory_patch_apply_engine_unit.sv
